// ----- rtl/core/bbc_pkg.sv -----
package bbc_pkg;

  // Window length and derived widths
  localparam int unsigned WINDOW  = 20;
  localparam int unsigned LOG_W   = $clog2(WINDOW);
  localparam int unsigned PTR_W   = (LOG_W > 0) ? LOG_W : 1;
  localparam int unsigned CNT_W   = $clog2(WINDOW + 2);
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned SUM_W   = PRICE_W + LOG_W;
  localparam int unsigned SQ_W    = 2 * PRICE_W + LOG_W;
  localparam int unsigned PROD_W  = 2 * SUM_W;
  localparam int unsigned VAR_W   = SQ_W + LOG_W;
  localparam int unsigned CMP_W   = ((PROD_W > VAR_W) ? PROD_W : VAR_W) + 2;

  // Band codes
  localparam logic [1:0] BAND_ABOVE  = 2'd0;
  localparam logic [1:0] BAND_INSIDE = 2'd1;
  localparam logic [1:0] BAND_BELOW  = 2'd2;

  // One step of the per-word sequence, at most one high per cycle
  typedef struct packed {
    logic ld_sample;  // word accepted: latch price, square it, read old slot
    logic upd_sum;    // old sample out: square it, update sum, add price^2
    logic upd_sq;     // drop old^2, square the sum, form |N*x - S|
    logic calc_var;   // square the deviation, form N*Q - S*S
    logic write_res;  // band test into the result register
  } cmd_t;

endpackage

// ----- rtl/core/bbc_ram.sv -----
module bbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bbc_ctrl.sv -----
module bbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output bbc_pkg::cmd_t cmd_o
);

  import bbc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OLD  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_VAR  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       res_free;

  // Result register can take a new word when empty or being drained
  assign res_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);

  // Next state and step commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.ld_sample = 1'b1;
          state_d         = ST_OLD;
        end
      end
      ST_OLD: begin
        cmd_o.upd_sum = 1'b1;
        state_d       = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.upd_sq = 1'b1;
        state_d      = ST_VAR;
      end
      ST_VAR: begin
        cmd_o.calc_var = 1'b1;
        state_d        = ST_CMP;
      end
      ST_CMP: begin
        if (res_free) begin
          cmd_o.write_res = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.write_res) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

// ----- rtl/core/bbc_datapath.sv -----
module bbc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbc_pkg::cmd_t                 cmd_i,
  input  logic [bbc_pkg::PRICE_W-1:0]   price_i,
  output logic [1:0]                    band_signal_o,
  output logic                          ready_res_o
);

  import bbc_pkg::*;

  // Window state
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   seen_q, seen_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]    sq_q, sq_d;
  logic               full_q, full_d;
  // Per-word working registers
  logic [PRICE_W-1:0] x_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SUM_W-1:0]   mag_q;
  logic               neg_q;
  logic [VAR_W-1:0]   v_q;
  logic [1:0]         band_q;
  logic               rdy_q;

  logic [PRICE_W-1:0] old_s;
  logic [SUM_W-1:0]   mul_op;
  logic [PROD_W-1:0]  mul_res;
  logic [SUM_W-1:0]   old_sub;
  logic [SQ_W-1:0]    sq_sub;
  logic [SUM_W-1:0]   nx;
  logic               neg_d;
  logic [SUM_W-1:0]   mag_d;
  logic [VAR_W-1:0]   nq;
  logic [VAR_W-1:0]   ss;
  logic [VAR_W-1:0]   v_d;
  logic [CMP_W-1:0]   d2_ext;
  logic [CMP_W-1:0]   lim_ext;
  logic [1:0]         band_d;

  // Sample ring
  bbc_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd_sum),
    .waddr_i (ptr_q),
    .wdata_i (x_q),
    .re_i    (cmd_i.ld_sample),
    .raddr_i (ptr_q),
    .rdata_o (old_s)
  );

  // Shared squarer
  always_comb begin
    mul_op = '0;
    if (cmd_i.ld_sample) begin
      mul_op = SUM_W'(price_i);
    end else if (cmd_i.upd_sum) begin
      mul_op = SUM_W'(old_s);
    end else if (cmd_i.upd_sq) begin
      mul_op = sum_q;
    end else if (cmd_i.calc_var) begin
      mul_op = mag_q;
    end
  end
  assign mul_res = PROD_W'(mul_op) * PROD_W'(mul_op);

  // Ring pointer, count and running sum
  assign old_sub = (seen_q >= CNT_W'(WINDOW)) ? SUM_W'(old_s) : '0;
  always_comb begin
    ptr_d  = ptr_q;
    seen_d = seen_q;
    sum_d  = sum_q;
    full_d = full_q;
    if (cmd_i.upd_sum) begin
      ptr_d  = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
      seen_d = (seen_q <= CNT_W'(WINDOW)) ? seen_q + CNT_W'(1) : seen_q;
      sum_d  = sum_q + SUM_W'(x_q) - old_sub;
      full_d = (seen_q >= CNT_W'(WINDOW));
    end
  end

  // Running sum of squares: add price^2, then drop old^2 once full
  assign sq_sub = full_q ? SQ_W'(prod_q) : '0;
  always_comb begin
    sq_d = sq_q;
    if (cmd_i.upd_sum) begin
      sq_d = sq_q + SQ_W'(prod_q);
    end else if (cmd_i.upd_sq) begin
      sq_d = sq_q - sq_sub;
    end
  end

  // Deviation d = N*x - S, kept as sign and magnitude
  assign nx    = SUM_W'(x_q) * SUM_W'(WINDOW);
  assign neg_d = (nx < sum_q);
  assign mag_d = neg_d ? (sum_q - nx) : (nx - sum_q);

  // Scaled variance N*Q - S*S, clamped at zero
  assign nq  = VAR_W'(sq_q) * VAR_W'(WINDOW);
  assign ss  = VAR_W'(prod_q);
  assign v_d = (nq >= ss) ? (nq - ss) : '0;

  // Band test d*d > 4*V
  assign d2_ext  = CMP_W'(prod_q);
  assign lim_ext = CMP_W'(v_q) << 2;
  always_comb begin
    band_d = BAND_INSIDE;
    if (full_q && (d2_ext > lim_ext)) begin
      band_d = neg_q ? BAND_BELOW : BAND_ABOVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      seen_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      full_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      seen_q <= seen_d;
      sum_q  <= sum_d;
      sq_q   <= sq_d;
      full_q <= full_d;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sample) begin
      x_q <= price_i;
    end
    if (cmd_i.ld_sample || cmd_i.upd_sum || cmd_i.upd_sq || cmd_i.calc_var) begin
      prod_q <= mul_res;
    end
    if (cmd_i.upd_sq) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
    if (cmd_i.calc_var) begin
      v_q <= v_d;
    end
    if (cmd_i.write_res) begin
      band_q <= band_d;
      rdy_q  <= full_q;
    end
  end

  assign band_signal_o = band_q;
  assign ready_res_o   = rdy_q;

endmodule

// ----- rtl/core/bollinger_band_classifier_unit.sv -----
// Channel | dir | handshake                    | payload
// --------+-----+------------------------------+-------------------------------------
// s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[23:0] price
// m_axis  | out | m_axis_tvalid / m_axis_tready | tdata[1:0] band_signal, [2] ready_res
//
// A word is accepted, then passes the sum, square and variance steps; these four
// share one 29x29 squarer (price^2, old^2, sum^2, deviation^2); the band test loads the
// result register. A new word is accepted while the last result still waits.
// Reset clears the window pointer, count and sums; the sample ring needs none.
// A stalled output holds the next word in its final step until it drains.
module bollinger_band_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [23:0] price
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] band_signal, [2] ready_res, [7:3] zero
);

  import bbc_pkg::*;

  cmd_t       cmd;
  logic [1:0] band_signal;
  logic       ready_res;

  // Sequencer
  bbc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // Window arithmetic and band test
  bbc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .price_i       (s_axis_tdata[PRICE_W-1:0]),
    .band_signal_o (band_signal),
    .ready_res_o   (ready_res)
  );

  assign m_axis_tdata = {5'b0, ready_res, band_signal};

`ifndef ASSERT_OFF
  // Every accepted word starts the sum step next cycle
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> cmd.upd_sum)
    else $error("accepted word did not enter the sum step");

  // No word is taken while one is in progress
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.upd_sum || cmd.upd_sq || cmd.calc_var) |-> !s_axis_tready)
    else $error("input ready while a word is in progress");

  // Steps never fire together
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one step command active");

  // A written result is presented next cycle with a legal band code
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_res |=> m_axis_tvalid && (m_axis_tdata[1:0] != 2'd3))
    else $error("result not presented or band code illegal");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import bbc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PRICE_MAX    = 24'hFFFFFF;

  // Expected band word and one row of the directed table
  typedef struct packed {
    logic [1:0] band;
    logic       ready;
  } band_word_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               typed;   // 1: use the band/ready typed in below
    logic [1:0]         band;
    logic               ready;
  } price_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [23:0] price
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [1:0] band_signal, [2] ready_res

  band_word_t  pending_bands[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        steady_flow = 1'b0;  // no idling on either side while set

  // Mirror of the block's window
  logic [PRICE_W-1:0] window_ring [WINDOW];
  int unsigned        window_ptr = 0;
  int unsigned        window_seen = 0;
  logic [63:0]        window_total = '0;
  logic [63:0]        window_sq_total = '0;

  // Random price walk
  int                 walk_level = 24'h400000;
  logic [PRICE_W-1:0] last_price = '0;

  bollinger_band_classifier_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Update the window with one price and classify it against the bands
  function automatic band_word_t predict_band(input logic [PRICE_W-1:0] price);
    logic [63:0] x;
    logic [63:0] old_sample;
    logic [63:0] n_x;
    logic [63:0] n_q;
    logic [63:0] s_sq;
    logic [63:0] spread;
    logic [63:0] dev;
    logic        is_low;
    band_word_t  res;
    x = 64'(price);
    res.band = BAND_INSIDE;
    res.ready = 1'b0;
    if (window_seen >= WINDOW) begin
      old_sample = 64'(window_ring[window_ptr]);
      window_total -= old_sample;
      window_sq_total -= old_sample * old_sample;
    end
    window_ring[window_ptr] = price;
    window_total += x;
    window_sq_total += x * x;
    window_ptr = (window_ptr + 1 >= WINDOW) ? 0 : window_ptr + 1;
    if (window_seen <= WINDOW) window_seen++;
    if (window_seen > WINDOW) begin
      res.ready = 1'b1;
      n_x = 64'(WINDOW) * x;
      n_q = 64'(WINDOW) * window_sq_total;
      s_sq = window_total * window_total;
      spread = (n_q >= s_sq) ? n_q - s_sq : '0;
      is_low = n_x < window_total;
      dev = is_low ? window_total - n_x : n_x - window_total;
      // on the band itself still counts as inside
      if (dev * dev > spread * 4) res.band = is_low ? BAND_BELOW : BAND_ABOVE;
    end
    return res;
  endfunction

  function automatic int clamp_price(input int level);
    if (level < 0) return 0;
    if (level > int'(PRICE_MAX)) return int'(PRICE_MAX);
    return level;
  endfunction

  // Mostly a drifting price, with spikes, flat runs, jumps and raw noise
  function automatic logic [PRICE_W-1:0] next_price();
    int unsigned pick;
    int          jump;
    logic [PRICE_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      walk_level = $urandom_range(0, PRICE_MAX);
      p = PRICE_W'(walk_level);
    end else if (pick < 5) begin
      walk_level = ($urandom_range(0, 1) != 0) ? int'(PRICE_MAX) : 0;
      p = PRICE_W'(walk_level);
    end else if (pick < 15) begin
      p = PRICE_W'($urandom());
    end else if (pick < 25) begin
      p = last_price;
    end else if (pick < 35) begin
      jump = int'($urandom_range(50000, 3000000));
      if ($urandom_range(0, 1) != 0) jump = -jump;
      p = PRICE_W'(clamp_price(walk_level + jump));
    end else if (pick < 45) begin
      walk_level = clamp_price(walk_level + int'($urandom_range(0, 6)) - 3);
      p = PRICE_W'(walk_level);
    end else begin
      walk_level = clamp_price(walk_level + int'($urandom_range(0, 4000)) - 2000);
      p = PRICE_W'(walk_level);
    end
    last_price = p;
    return p;
  endfunction

  // Offer one price word, record what it should produce once accepted
  task automatic send_price(input price_row_t row);
    band_word_t predicted;
    while (!steady_flow && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.price;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_band(row.price);
    if (row.typed) begin
      predicted.band  = row.band;
      predicted.ready = row.ready;
    end
    pending_bands = {pending_bands, predicted};
  endtask

  // Stimulus
  initial begin
    price_row_t directed_rows [25];
    price_row_t row;
    directed_rows = '{
      // warm-up: held inside, not ready, whatever the price
      '{24'h000000, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b0},
      // 19 at full scale, then zero: far below the lower band
      '{24'h000000, 1'b1, BAND_BELOW,  1'b1},
      // same window again, full scale sits inside
      '{24'hFFFFFF, 1'b1, BAND_INSIDE, 1'b1},
      '{24'h555555, 1'b0, BAND_INSIDE, 1'b0},
      '{24'hAAAAAA, 1'b0, BAND_INSIDE, 1'b0},
      '{24'h000000, 1'b0, BAND_INSIDE, 1'b0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_price(directed_rows[i]);

    row.typed = 1'b0;
    row.band  = BAND_INSIDE;
    row.ready = 1'b0;
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // drain completely once, mid-run
      if (n == 150) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_bands.size() != 0) @(posedge clk_i);
      end
      if (n == 300) steady_flow <= 1'b1;
      if (n == 420) steady_flow <= 1'b0;
      row.price = next_price();
      send_price(row);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_bands.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 16);
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin : band_check
    band_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bands.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual band %0d ready %0d",
                 $time, m_axis_tdata[1:0], m_axis_tdata[2]);
        mismatch_count++;
      end else begin
        want = pending_bands.pop_front();
        if (m_axis_tdata[1:0] !== want.band) begin
          $display("%0t: band_signal expected %0d actual %0d",
                   $time, want.band, m_axis_tdata[1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[2] !== want.ready) begin
          $display("%0t: ready_res expected %0d actual %0d",
                   $time, want.ready, m_axis_tdata[2]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
